// ===== rtl/frb_pkg.sv =====
// shared types, codes and constants of the flit retransmission buffer
`default_nettype none

package frb_pkg;

  localparam int ID_W      = 32;
  localparam int GEV_W     = 8;
  localparam int PAY_W     = 64;
  localparam int KIND_IN_W = 3;
  localparam int KIND_W    = 2;
  localparam int DEPTH_W   = 5;

  localparam int MAX_ENTRIES_DEF  = 16;
  localparam int PAYLOAD_BITS_DEF = 64;
  localparam int GEV_BITS_DEF     = 8;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd10;

  localparam logic OPC_STORE   = 1'b0;
  localparam logic OPC_REQUEST = 1'b1;

  localparam logic PORT_FORWARD = 1'b0;
  localparam logic PORT_RETRANS = 1'b1;

  localparam logic [KIND_IN_W-1:0] KIND_DATA     = 3'd0;
  localparam logic [KIND_IN_W-1:0] KIND_MAC      = 3'd1;
  localparam logic [KIND_IN_W-1:0] KIND_SPLIT2   = 3'd3;
  localparam logic [KIND_IN_W-1:0] KIND_DATA_MAC = 3'd4;

  typedef enum logic [1:0] {
    OP_STORE     = 2'd0,
    OP_READ      = 2'd1,
    OP_READ_PAIR = 2'd2
  } frb_op_t;

  typedef struct packed {
    logic                 opcode;
    logic                 is_coded;
    logic [ID_W-1:0]      flit_id;
    logic [GEV_W-1:0]     gen_vector;
    logic [KIND_IN_W-1:0] kind;
    logic [PAY_W-1:0]     payload;
  } frb_in_t;

  typedef struct packed {
    logic              out_port;
    logic              out_coded;
    logic [ID_W-1:0]   out_id;
    logic [GEV_W-1:0]  out_gen_vector;
    logic [KIND_W-1:0] out_kind;
    logic [PAY_W-1:0]  out_payload;
    logic              last;
  } frb_out_t;

  typedef struct packed {
    frb_op_t           op;
    logic              is_coded;
    logic [ID_W-1:0]   flit_id;
    logic [GEV_W-1:0]  gen_vector;
    logic [GEV_W-1:0]  gkey;
    logic [KIND_W-1:0] kind;
    logic              cache;
    logic [PAY_W-1:0]  payload;
  } frb_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/frb_front.sv =====
// front end: accepts input transfers and classifies them into commands
`default_nettype none

module frb_front import frb_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  parameter int GEV_BITS     = GEV_BITS_DEF
) (
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire frb_in_t  in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output frb_cmd_t      q_cmd
);

  localparam int KG_W = (GEV_BITS < GEV_W) ? GEV_BITS : GEV_W;

  logic drop;

  assign in_ready = !q_full;

  always_comb begin
    drop            = 1'b0;
    q_cmd.op        = OP_STORE;
    q_cmd.is_coded  = in_data.is_coded;
    q_cmd.flit_id   = in_data.flit_id;
    q_cmd.gen_vector = in_data.gen_vector;
    q_cmd.gkey      = in_data.is_coded ? GEV_W'(in_data.gen_vector[KG_W-1:0]) : '0;
    q_cmd.kind      = in_data.kind[KIND_W-1:0];
    q_cmd.cache     = 1'b0;
    q_cmd.payload   = PAY_W'(in_data.payload[PAYLOAD_BITS-1:0]);
    if (in_data.opcode == OPC_STORE) begin
      q_cmd.op    = OP_STORE;
      q_cmd.cache = (in_data.kind <= KIND_SPLIT2);
    end else if (in_data.kind <= KIND_SPLIT2) begin
      q_cmd.op = OP_READ;
    end else if (in_data.kind == KIND_DATA_MAC) begin
      q_cmd.op = OP_READ_PAIR;
    end else begin
      drop = 1'b1;
    end
  end

  assign q_push = in_valid && in_ready && !drop;

endmodule

`default_nettype wire

// ===== rtl/frb_queue.sv =====
// two-entry command queue between front end and table engine
`default_nettype none

module frb_queue import frb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire frb_cmd_t push_cmd,
  output logic          full,
  output logic          head_valid,
  output frb_cmd_t      head_cmd,
  input  wire logic     pop
);

  frb_cmd_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frb_back.sv =====
// table engine: ring tables, key lookup, trim and insert, result register
`default_nettype none

module frb_back import frb_pkg::*; #(
  parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  parameter int GEV_BITS     = GEV_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic [DEPTH_W-1:0] cfg_data,
  input  wire logic               q_valid,
  input  wire frb_cmd_t           q_cmd,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output frb_out_t                out_data
);

  localparam int KG_W  = (GEV_BITS < GEV_W) ? GEV_BITS : GEV_W;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;
  localparam int AW    = $clog2(2 * MAX_ENTRIES);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [KG_W-1:0]   gev;
    logic [KIND_W-1:0] kind;
  } key_t;

  typedef enum logic [2:0] {
    ST_LOOK = 3'b001,
    ST_EXEC = 3'b010,
    ST_MAC  = 3'b100
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [DEPTH_W-1:0] depth_r;
  logic [CNT_W-1:0]   cnt_r [2];
  logic [IDX_W-1:0]   old_r [2];
  key_t               key_r [2][MAX_ENTRIES];
  logic [PAYLOAD_BITS-1:0] pay_mem [2*MAX_ENTRIES];
  logic [PAYLOAD_BITS-1:0] rd_data_r;

  logic             hit_a_r, hit_b_r;
  logic [IDX_W-1:0] idx_b_r;

  frb_out_t out_data_r, out_data_nxt;
  logic     out_valid_r;
  logic     out_load, out_free;

  logic                  tsel;
  logic [KIND_W-1:0]     kind_a;
  key_t                  want_a, want_b;
  logic [MAX_ENTRIES-1:0] match_a, match_b;
  logic [IDX_W-1:0]      idx_a, idx_b;
  logic [CNT_W-1:0]      depth_eff;

  logic [CNT_W-1:0] c_trim [2];
  logic [CNT_W-1:0] c_fin [2];
  logic [CNT_W-1:0] adv [2];
  logic [CNT_W-1:0] cnt_nxt [2];
  logic [IDX_W-1:0] old_nxt [2];
  logic [IDX_W-1:0] waddr [2];
  logic             extra [2];
  logic             ins [2];

  logic          upd, rd_en, rd_sel_b, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;

  function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
    return (s >= SUM_W'(MAX_ENTRIES)) ? IDX_W'(s - SUM_W'(MAX_ENTRIES)) : IDX_W'(s);
  endfunction

  function automatic logic [AW-1:0] mem_addr(input logic tbl, input logic [IDX_W-1:0] idx);
    return tbl ? (AW'(idx) + AW'(MAX_ENTRIES)) : AW'(idx);
  endfunction

  assign tsel      = q_cmd.is_coded;
  assign out_free  = !out_valid_r || out_ready;
  assign depth_eff = (CMP_W'(depth_r) > CMP_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                              : CNT_W'(depth_r);

  // parallel key compare over live entries of the selected table
  always_comb begin
    logic [SUM_W-1:0] rel;
    kind_a = (q_cmd.op == OP_READ_PAIR) ? KIND_DATA[KIND_W-1:0] : q_cmd.kind;
    want_a = '{id: q_cmd.flit_id, gev: q_cmd.gkey[KG_W-1:0], kind: kind_a};
    want_b = '{id: q_cmd.flit_id, gev: q_cmd.gkey[KG_W-1:0], kind: KIND_MAC[KIND_W-1:0]};
    idx_a  = '0;
    idx_b  = '0;
    rel    = '0;
    for (int e = 0; e < MAX_ENTRIES; e++) begin
      if (SUM_W'(e) >= SUM_W'(old_r[tsel])) begin
        rel = SUM_W'(e) - SUM_W'(old_r[tsel]);
      end else begin
        rel = SUM_W'(e) + SUM_W'(MAX_ENTRIES) - SUM_W'(old_r[tsel]);
      end
      match_a[e] = (rel < SUM_W'(cnt_r[tsel])) && (key_r[tsel][e] == want_a);
      match_b[e] = (rel < SUM_W'(cnt_r[tsel])) && (key_r[tsel][e] == want_b);
      idx_a = idx_a | (match_a[e] ? IDX_W'(e) : '0);
      idx_b = idx_b | (match_b[e] ? IDX_W'(e) : '0);
    end
  end

  // trim both tables to depth, target table to one less before an insert
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      c_trim[t]  = (cnt_r[t] > depth_eff) ? depth_eff : cnt_r[t];
      ins[t]     = (tsel == t[0]) && q_cmd.cache && !hit_a_r && (depth_eff != '0);
      extra[t]   = ins[t] && (c_trim[t] == depth_eff);
      c_fin[t]   = c_trim[t] - CNT_W'(extra[t]);
      adv[t]     = (cnt_r[t] - c_trim[t]) + CNT_W'(extra[t]);
      old_nxt[t] = wrap(SUM_W'(old_r[t]) + SUM_W'(adv[t]));
      waddr[t]   = wrap(SUM_W'(old_nxt[t]) + SUM_W'(c_fin[t]));
      cnt_nxt[t] = ins[t] ? (c_fin[t] + CNT_W'(1)) : c_fin[t];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    q_pop        = 1'b0;
    upd          = 1'b0;
    rd_en        = 1'b0;
    rd_sel_b     = 1'b0;
    out_load     = 1'b0;
    out_data_nxt = '{out_port: PORT_RETRANS, out_coded: q_cmd.is_coded,
                     out_id: q_cmd.flit_id, out_gen_vector: q_cmd.gkey,
                     out_kind: q_cmd.kind, out_payload: PAY_W'(rd_data_r),
                     last: 1'b1};
    case (state_r)
      ST_LOOK: begin
        if (q_valid) begin
          rd_en     = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (q_cmd.op)
          OP_STORE: begin
            if (out_free) begin
              upd                         = 1'b1;
              out_load                    = 1'b1;
              out_data_nxt.out_port       = PORT_FORWARD;
              out_data_nxt.out_gen_vector = q_cmd.gen_vector;
              out_data_nxt.out_payload    = q_cmd.payload;
              q_pop                       = 1'b1;
              state_nxt                   = ST_LOOK;
            end
          end
          OP_READ: begin
            if (!hit_a_r) begin
              q_pop     = 1'b1;
              state_nxt = ST_LOOK;
            end else if (out_free) begin
              out_load  = 1'b1;
              q_pop     = 1'b1;
              state_nxt = ST_LOOK;
            end
          end
          OP_READ_PAIR: begin
            if (!(hit_a_r && hit_b_r)) begin
              q_pop     = 1'b1;
              state_nxt = ST_LOOK;
            end else if (out_free) begin
              out_load              = 1'b1;
              out_data_nxt.out_kind = KIND_DATA[KIND_W-1:0];
              out_data_nxt.last     = 1'b0;
              rd_en                 = 1'b1;
              rd_sel_b              = 1'b1;
              state_nxt             = ST_MAC;
            end
          end
          default: begin
            q_pop     = 1'b1;
            state_nxt = ST_LOOK;
          end
        endcase
      end
      ST_MAC: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_data_nxt.out_kind = KIND_MAC[KIND_W-1:0];
          q_pop                 = 1'b1;
          state_nxt             = ST_LOOK;
        end
      end
      default: begin
        state_nxt = ST_LOOK;
      end
    endcase
  end

  assign rd_addr = rd_sel_b ? mem_addr(tsel, idx_b_r) : mem_addr(tsel, idx_a);
  assign wr_en   = upd && ins[tsel];
  assign wr_addr = mem_addr(tsel, waddr[tsel]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOOK;
      depth_r     <= DEPTH_RESET;
      out_valid_r <= 1'b0;
      for (int t = 0; t < 2; t++) begin
        cnt_r[t] <= '0;
        old_r[t] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        depth_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (upd) begin
        for (int t = 0; t < 2; t++) begin
          cnt_r[t] <= cnt_nxt[t];
          old_r[t] <= old_nxt[t];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK && q_valid) begin
      hit_a_r <= |match_a;
      hit_b_r <= |match_b;
      idx_b_r <= idx_b;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
    if (wr_en) begin
      key_r[tsel][waddr[tsel]] <= want_a;
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pay_mem[wr_addr] <= q_cmd.payload[PAYLOAD_BITS-1:0];
    end
    if (rd_en) begin
      rd_data_r <= pay_mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/flit_retransmission_buffer.sv =====
// top level of the flit retransmission buffer
// an input is queued, looked up and executed in the table engine, then registered;
// execute waits for a free output; the engine takes one queued command at a time;
// a data+mac request that hits adds a mac step, a request that misses emits nothing
// reset: tables empty, depth 10, output empty; no clearing pass, ready right after reset
`default_nettype none

module flit_retransmission_buffer import frb_pkg::*; #(
  parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  parameter int GEV_BITS     = GEV_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [DEPTH_W-1:0] cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire frb_in_t            in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output frb_out_t                out_data
);

  logic     q_full, q_push, q_head_valid, q_pop;
  frb_cmd_t q_push_cmd, q_head_cmd;

  assign cfg_ready = 1'b1;

  frb_front #(
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .GEV_BITS     (GEV_BITS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  frb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop)
  );

  frb_back #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .GEV_BITS     (GEV_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (q_head_valid),
    .q_cmd     (q_head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== test/flit_retransmission_buffer_test.sv =====
// self-checking testbench of the flit retransmission buffer with a flit cache scoreboard
`default_nettype none

module flit_retransmission_buffer_test;
  import frb_pkg::*;

  localparam logic [KIND_IN_W-1:0] KIND_SPLIT1 = 3'd2;

  class flit_scoreboard;
    logic [ID_W-1:0]      key_id   [2][MAX_ENTRIES_DEF];
    logic [GEV_W-1:0]     key_gev  [2][MAX_ENTRIES_DEF];
    logic [KIND_IN_W-1:0] key_kind [2][MAX_ENTRIES_DEF];
    logic [PAY_W-1:0]     cached   [2][MAX_ENTRIES_DEF];
    int unsigned          oldest   [2];
    int unsigned          fill     [2];
    int unsigned          depth;
    frb_out_t             awaited  [$];
    int                   errors;

    function new();
      depth     = 32'(DEPTH_RESET);
      oldest[0] = 0;
      oldest[1] = 0;
      fill[0]   = 0;
      fill[1]   = 0;
      errors    = 0;
    endfunction

    function void set_depth(logic [DEPTH_W-1:0] d);
      depth = (32'(d) > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : 32'(d);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int locate(int t, logic [ID_W-1:0] id, logic [GEV_W-1:0] gev,
                        logic [KIND_IN_W-1:0] kind);
      int slot;
      for (int i = 0; i < fill[t]; i++) begin
        slot = (oldest[t] + i) % MAX_ENTRIES_DEF;
        if (key_id[t][slot] == id && key_gev[t][slot] == gev && key_kind[t][slot] == kind)
          return slot;
      end
      return -1;
    endfunction

    function void shed(int t, int unsigned limit);
      while (fill[t] > limit) begin
        oldest[t] = (oldest[t] + 1) % MAX_ENTRIES_DEF;
        fill[t]--;
      end
    endfunction

    function frb_out_t make_flit(logic port, logic coded, logic [ID_W-1:0] id,
                                 logic [GEV_W-1:0] gev, logic [KIND_IN_W-1:0] kind,
                                 logic [PAY_W-1:0] pay, logic fin);
      frb_out_t r;
      r.out_port       = port;
      r.out_coded      = coded;
      r.out_id         = id;
      r.out_gen_vector = gev;
      r.out_kind       = kind[KIND_W-1:0];
      r.out_payload    = pay;
      r.last           = fin;
      return r;
    endfunction

    function void note_input(frb_in_t it);
      int t;
      int hit_a;
      int hit_b;
      int slot;
      bit dup;
      logic [GEV_W-1:0] gkey;
      t    = 32'(it.is_coded);
      gkey = it.is_coded ? it.gen_vector : '0;
      if (it.opcode == OPC_STORE) begin
        dup = (it.kind <= KIND_SPLIT2) && (locate(t, it.flit_id, gkey, it.kind) >= 0);
        shed(0, depth);
        shed(1, depth);
        if (it.kind <= KIND_SPLIT2 && !dup && depth > 0) begin
          shed(t, depth - 1);
          slot = (oldest[t] + fill[t]) % MAX_ENTRIES_DEF;
          key_id[t][slot]   = it.flit_id;
          key_gev[t][slot]  = gkey;
          key_kind[t][slot] = it.kind;
          cached[t][slot]   = it.payload;
          fill[t]++;
        end
        awaited.push_back(make_flit(PORT_FORWARD, it.is_coded, it.flit_id, it.gen_vector,
                                    it.kind, it.payload, 1'b1));
      end else if (it.kind <= KIND_SPLIT2) begin
        hit_a = locate(t, it.flit_id, gkey, it.kind);
        if (hit_a >= 0)
          awaited.push_back(make_flit(PORT_RETRANS, it.is_coded, it.flit_id, gkey, it.kind,
                                      cached[t][hit_a], 1'b1));
      end else if (it.kind == KIND_DATA_MAC) begin
        hit_a = locate(t, it.flit_id, gkey, KIND_DATA);
        hit_b = locate(t, it.flit_id, gkey, KIND_MAC);
        if (hit_a >= 0 && hit_b >= 0) begin
          awaited.push_back(make_flit(PORT_RETRANS, it.is_coded, it.flit_id, gkey, KIND_DATA,
                                      cached[t][hit_a], 1'b0));
          awaited.push_back(make_flit(PORT_RETRANS, it.is_coded, it.flit_id, gkey, KIND_MAC,
                                      cached[t][hit_b], 1'b1));
        end
      end
    endfunction

    function void report(string field, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    endfunction

    function void check_result(frb_out_t got);
      frb_out_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none actual %h", $time, got);
        return;
      end
      want = awaited.pop_front();
      if (got.out_port !== want.out_port) report("out_port", want.out_port, got.out_port);
      if (got.out_coded !== want.out_coded) report("out_coded", want.out_coded, got.out_coded);
      if (got.out_id !== want.out_id) report("out_id", want.out_id, got.out_id);
      if (got.out_gen_vector !== want.out_gen_vector)
        report("out_gen_vector", want.out_gen_vector, got.out_gen_vector);
      if (got.out_kind !== want.out_kind) report("out_kind", want.out_kind, got.out_kind);
      if (got.out_payload !== want.out_payload)
        report("out_payload", want.out_payload, got.out_payload);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [DEPTH_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  frb_in_t            in_data;
  logic               out_valid;
  logic               out_ready;
  frb_out_t           out_data;

  flit_scoreboard   board;
  bit               calm = 1'b0;
  int               send_rate = 0;
  int               recv_rate = 0;
  logic [ID_W-1:0]  id_pool  [8];
  logic [GEV_W-1:0] gev_pool [4];

  flit_retransmission_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < recv_rate) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic frb_in_t make_item(logic opc, logic coded, logic [ID_W-1:0] id,
                                        logic [GEV_W-1:0] gev, logic [KIND_IN_W-1:0] kind,
                                        logic [PAY_W-1:0] pay);
    frb_in_t it;
    it.opcode     = opc;
    it.is_coded   = coded;
    it.flit_id    = id;
    it.gen_vector = gev;
    it.kind       = kind;
    it.payload    = pay;
    return it;
  endfunction

  function automatic logic [PAY_W-1:0] random_payload();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) < 8) return id_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [GEV_W-1:0] pick_gev();
    if ($urandom_range(0, 9) < 8) return gev_pool[$urandom_range(0, 3)];
    return GEV_W'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input frb_in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(it);
  endtask

  task automatic idle_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic pace_sender();
    if (!calm && $urandom_range(0, 99) < send_rate) idle_input($urandom_range(1, 14));
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_depth(input logic [DEPTH_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_depth(d);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    pace_sender(); send_item(make_item(OPC_STORE, 1'b0, '0, '1, KIND_DATA, '0));
    pace_sender(); send_item(make_item(OPC_STORE, 1'b0, '0, '0, KIND_MAC, '1));
    pace_sender();
    send_item(make_item(OPC_STORE, 1'b0, '0, 8'h5a, KIND_SPLIT1, 64'ha5a5_a5a5_a5a5_a5a5));
    pace_sender();
    send_item(make_item(OPC_STORE, 1'b0, '0, 8'ha5, KIND_SPLIT2, 64'h5a5a_5a5a_5a5a_5a5a));
    // same key again, first copy stays
    pace_sender();
    send_item(make_item(OPC_STORE, 1'b0, '0, '0, KIND_DATA, 64'h0123_4567_89ab_cdef));
    pace_sender();
    send_item(make_item(OPC_STORE, 1'b0, '1, '1, KIND_DATA_MAC, 64'hdead_beef_0000_0001));
    pace_sender(); send_item(make_item(OPC_STORE, 1'b0, '1, '0, '1, 64'hfeed_0000_0000_0000));
    pace_sender(); send_item(make_item(OPC_STORE, 1'b1, '1, '1, KIND_DATA, '1));
    pace_sender();
    send_item(make_item(OPC_STORE, 1'b1, '1, '1, KIND_MAC, 64'h8000_0000_0000_0001));
    pace_sender();
    send_item(make_item(OPC_STORE, 1'b1, '1, '0, KIND_DATA, 64'h7fff_ffff_ffff_fffe));
    pace_sender(); send_item(make_item(OPC_REQUEST, 1'b0, '0, 8'h3c, KIND_DATA, '0));
    for (int k = KIND_MAC; k <= KIND_SPLIT2; k++) begin
      pace_sender(); send_item(make_item(OPC_REQUEST, 1'b0, '0, '1, KIND_IN_W'(k), '0));
    end
    pace_sender(); send_item(make_item(OPC_REQUEST, 1'b0, '0, '0, KIND_DATA_MAC, '1));
    pace_sender(); send_item(make_item(OPC_REQUEST, 1'b1, '1, '1, KIND_DATA_MAC, '0));
    // mac half missing
    pace_sender(); send_item(make_item(OPC_REQUEST, 1'b1, '1, '0, KIND_DATA_MAC, '0));
    pace_sender(); send_item(make_item(OPC_REQUEST, 1'b1, '1, '0, KIND_DATA, '0));
    pace_sender(); send_item(make_item(OPC_REQUEST, 1'b0, '1, '0, KIND_DATA, '0));
    for (int k = KIND_DATA_MAC + 1; k < 2 ** KIND_IN_W; k++) begin
      pace_sender(); send_item(make_item(OPC_REQUEST, 1'b0, '0, '0, KIND_IN_W'(k), '0));
    end
    pace_sender(); send_item(make_item(OPC_REQUEST, 1'b1, '0, '1, KIND_DATA, '0));
  endtask

  task automatic random_burst(output int counted);
    int                   pick;
    logic                 coded;
    logic                 opc;
    logic [ID_W-1:0]      id;
    logic [GEV_W-1:0]     gev;
    logic [KIND_IN_W-1:0] kind;
    if ($urandom_range(0, 99) == 0) id_pool[$urandom_range(0, 7)] = $urandom;
    if ($urandom_range(0, 99) == 0)
      gev_pool[$urandom_range(0, 3)] = GEV_W'($urandom_range(0, 255));
    pick    = $urandom_range(0, 99);
    coded   = 1'($urandom_range(0, 1));
    id      = pick_id();
    gev     = pick_gev();
    counted = 1;
    if (pick < 35) begin
      // data, mac, then pair request on one key
      pace_sender(); send_item(make_item(OPC_STORE, coded, id, gev, KIND_DATA, random_payload()));
      pace_sender(); send_item(make_item(OPC_STORE, coded, id, gev, KIND_MAC, random_payload()));
      pace_sender();
      send_item(make_item(OPC_REQUEST, coded, id, gev, KIND_DATA_MAC, random_payload()));
      counted = 3;
    end else if (pick < 60) begin
      kind = KIND_IN_W'($urandom_range(KIND_DATA, KIND_SPLIT2));
      pace_sender(); send_item(make_item(OPC_STORE, coded, id, gev, kind, random_payload()));
    end else if (pick < 90) begin
      kind = KIND_IN_W'($urandom_range(KIND_DATA, KIND_DATA_MAC));
      pace_sender(); send_item(make_item(OPC_REQUEST, coded, id, gev, kind, random_payload()));
    end else begin
      opc  = 1'($urandom_range(0, 1));
      kind = KIND_IN_W'($urandom_range(KIND_DATA_MAC, 2 ** KIND_IN_W - 1));
      if ($urandom_range(0, 1) == 1) id = $urandom;
      pace_sender(); send_item(make_item(opc, coded, id, gev, kind, random_payload()));
      counted = (opc == OPC_STORE || kind == KIND_DATA_MAC) ? 1 : 0;
    end
  endtask

  initial begin
    logic [DEPTH_W-1:0] depth_plan [8];
    int                 counted;
    int                 sent;
    bit                 paused;
    board     = new();
    paused    = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    id_pool[0]  = '0;
    id_pool[1]  = '1;
    id_pool[2]  = 32'd1;
    id_pool[3]  = 32'd2;
    for (int i = 4; i < 8; i++) id_pool[i] = $urandom;
    gev_pool[0] = '0;
    gev_pool[1] = '1;
    gev_pool[2] = GEV_W'($urandom_range(0, 255));
    gev_pool[3] = GEV_W'($urandom_range(0, 255));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_rate = 20;
    recv_rate = 20;
    run_directed();
    depth_plan = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd3, 5'd10, 5'd17, 5'd10};
    depth_plan[5] = DEPTH_W'($urandom_range(2, 15));
    for (int p = 0; p < 8; p++) begin
      drain_all();
      write_depth(depth_plan[p]);
      send_rate = 15 * $urandom_range(0, 2);
      recv_rate = 15 * $urandom_range(0, 2);
      sent = 0;
      while (sent < 118) begin
        if (p == 7 && sent >= 18) calm = 1'b1;
        if (p == 3 && sent >= 60 && !paused) begin
          drain_all();
          paused = 1'b1;
        end
        random_burst(counted);
        sent += counted;
      end
    end
    drain_all();
    if (board.errors == 0 && board.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/frb_pkg.sv
rtl/frb_front.sv
rtl/frb_queue.sv
rtl/frb_back.sv
rtl/flit_retransmission_buffer.sv
test/flit_retransmission_buffer_test.sv
